@@ rtl/lalf_pkg.sv @@
package lalf_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int ADDR_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 3;

    // Received packet checks
    localparam logic [BYTE_W-1:0] LEN_VALID  = 8'h0E;
    localparam logic [BYTE_W-1:0] KIND_VALID = 8'd17;
    localparam logic [BYTE_W-1:0] LCMD_A     = 8'd3;
    localparam logic [BYTE_W-1:0] LCMD_B     = 8'd5;
    localparam logic [BYTE_W-1:0] LCMD_C     = 8'd7;

    // Input word kind (s_tuser)
    localparam logic CMD_LEARN = 1'b0;
    localparam logic CMD_SEND  = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_KNOWN  = 3'd1,
        ST_FULL   = 3'd2,
        ST_REJECT = 3'd3,
        ST_FRAME  = 3'd4,
        ST_NOLAMP = 3'd5
    } status_t;

    // Flags from the shared compare unit
    typedef struct packed {
        logic used;   // byte 0 nonzero
        logic lamp;   // bytes 0..3 nonzero
        logic hit;    // entry equals key in all 8 bytes
    } match_t;

endpackage

@@ rtl/lamp_address_learning_and_framing_core.sv @@
// Lamp address learning and framing core. Holds a table of TABLE_ENTRIES
// 64-bit lamp addresses and an 8-bit wrapping frame sequence counter.
// s_tuser = 0 means a received radio packet: it is checked (length 14,
// kind 17, command 3/5/7), and a valid new address goes into the lowest
// empty entry (byte 0 zero means empty). One result word comes back with
// status added/known/full/rejected and the lamp count (entries with bytes
// 0..3 nonzero, low 5 bits). s_tuser = 1 sends: one frame word per used
// entry in table order, each with the next sequence number, tlast on the
// final one; an empty table gives a single "no lamps" word.
// Timing: one word at a time, s_tready is high only when idle. A rejected
// packet or a send to an empty table goes straight to the output
// handshake. A valid packet scans every entry, one table read and compare
// per cycle through the single compare unit, then makes the decision and
// write, then the handshake. A send reads and checks each entry in turn
// (registered table read, then check) up to the last used entry, plus one
// handshake per frame. The table uses per-entry valid bits, so it is
// usable straight out of reset with no clearing pass.
module lamp_address_learning_and_framing_core #(
    parameter int TABLE_ENTRIES = lalf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, low bit up: length_byte[7:0], address[71:8], kind_byte[79:72],
    //   lamp_cmd[87:80], hue[95:88], saturation[103:96], brightness[111:104]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lalf_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: command (0 learn, 1 send)
    input  logic                           s_tuser,
    // m_tdata, low bit up: lamp_count[4:0], frame_address[68:5],
    //   frame_cmd[76:69], frame_seq[84:77], frame_hue[92:85],
    //   frame_sat[100:93], frame_val[108:101], zero pad[111:109]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lalf_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [lalf_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        IDLE,
        LSCAN,    // issue reads, compare the previous word
        LTAIL,    // compare the final entry
        LDECIDE,  // add / known / full
        SRD,      // send: issue read
        SCHK,     // send: check entry, load frame
        OUT       // result word waiting
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic             efound_reg, efound_next;
    logic [IDX_W-1:0] eidx_reg, eidx_next;
    logic [CNT_W-1:0] used_cnt_reg, used_cnt_next;
    logic [CNT_W-1:0] lamp_cnt_reg, lamp_cnt_next;
    logic [CNT_W-1:0] seen_cnt_reg, seen_cnt_next;
    logic [7:0]       seq_reg, seq_next;

    // captured input word
    logic [lalf_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] hue_reg, hue_next;
    logic [7:0] sat_reg, sat_next;
    logic [7:0] val_reg, val_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    lalf_pkg::status_t           m_status_reg, m_status_next;
    logic [lalf_pkg::COUNT_W-1:0] m_count_reg, m_count_next;
    logic [lalf_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [7:0] m_cmd_reg, m_cmd_next;
    logic [7:0] m_seq_reg, m_seq_next;
    logic [7:0] m_hue_reg, m_hue_next;
    logic [7:0] m_sat_reg, m_sat_next;
    logic [7:0] m_val_reg, m_val_next;
    logic       m_last_reg, m_last_next;

    // table and compare unit
    logic                        wr_en;
    logic [lalf_pkg::ADDR_W-1:0] tbl_rd_data;
    logic [lalf_pkg::ADDR_W-1:0] cmp_entry;
    lalf_pkg::match_t            flags;
    logic [CNT_W+lalf_pkg::COUNT_W-1:0] lamp_ext;

    // input fields
    logic [7:0]                  in_len;
    logic [lalf_pkg::ADDR_W-1:0] in_addr;
    logic [7:0]                  in_kind;
    logic [7:0]                  in_cmd;
    logic                        pkt_ok;

    assign in_len  = s_tdata[7:0];
    assign in_addr = s_tdata[71:8];
    assign in_kind = s_tdata[79:72];
    assign in_cmd  = s_tdata[87:80];
    assign pkt_ok  = (in_len == lalf_pkg::LEN_VALID) && (in_kind == lalf_pkg::KIND_VALID) &&
                     ((in_cmd == lalf_pkg::LCMD_A) || (in_cmd == lalf_pkg::LCMD_B) ||
                      (in_cmd == lalf_pkg::LCMD_C));

    lalf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_idx  (eidx_reg),
        .wr_data (addr_reg),
        .rd_idx  (idx_reg),
        .rd_data (tbl_rd_data)
    );

    // the compare unit also classifies the new address at decision time
    assign cmp_entry = (state_reg == LDECIDE) ? addr_reg : tbl_rd_data;

    lalf_match u_match (
        .entry (cmp_entry),
        .key   (addr_reg),
        .flags (flags)
    );

    assign wr_en = (state_reg == LDECIDE) && !hit_reg && efound_reg;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        chk_idx_next  = chk_idx_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        efound_next   = efound_reg;
        eidx_next     = eidx_reg;
        used_cnt_next = used_cnt_reg;
        lamp_cnt_next = lamp_cnt_reg;
        seen_cnt_next = seen_cnt_reg;
        seq_next      = seq_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;
        hue_next      = hue_reg;
        sat_next      = sat_reg;
        val_next      = val_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        m_cmd_next    = m_cmd_reg;
        m_seq_next    = m_seq_reg;
        m_hue_next    = m_hue_reg;
        m_sat_next    = m_sat_reg;
        m_val_next    = m_val_reg;
        m_last_next   = m_last_reg;
        lamp_ext      = '0;

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    addr_next = in_addr;
                    cmd_next  = in_cmd;
                    hue_next  = s_tdata[95:88];
                    sat_next  = s_tdata[103:96];
                    val_next  = s_tdata[111:104];
                    idx_next  = '0;
                    // status-only word unless a frame overrides
                    m_addr_next = '0;
                    m_cmd_next  = '0;
                    m_seq_next  = '0;
                    m_hue_next  = '0;
                    m_sat_next  = '0;
                    m_val_next  = '0;
                    m_last_next = 1'b1;
                    if (s_tuser == lalf_pkg::CMD_LEARN) begin
                        if (pkt_ok) begin
                            pend_next   = 1'b0;
                            hit_next    = 1'b0;
                            efound_next = 1'b0;
                            state_next  = LSCAN;
                        end else begin
                            m_status_next = lalf_pkg::ST_REJECT;
                            m_valid_next  = 1'b1;
                            state_next    = OUT;
                        end
                    end else begin
                        if (used_cnt_reg == '0) begin
                            m_status_next = lalf_pkg::ST_NOLAMP;
                            m_valid_next  = 1'b1;
                            state_next    = OUT;
                        end else begin
                            seen_cnt_next = '0;
                            state_next    = SRD;
                        end
                    end
                end
            end
            LSCAN, LTAIL: begin
                if (pend_reg) begin
                    if (flags.used && flags.hit) begin
                        hit_next = 1'b1;
                    end
                    if (!flags.used && !efound_reg) begin
                        efound_next = 1'b1;
                        eidx_next   = chk_idx_reg;
                    end
                end
                if (state_reg == LSCAN) begin
                    pend_next    = 1'b1;
                    chk_idx_next = idx_reg;
                    if (idx_reg == LAST_IDX) begin
                        state_next = LTAIL;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end else begin
                    state_next = LDECIDE;
                end
            end
            LDECIDE: begin
                priority if (hit_reg) begin
                    m_status_next = lalf_pkg::ST_KNOWN;
                end else if (efound_reg) begin
                    m_status_next = lalf_pkg::ST_ADDED;
                    if (flags.used) begin
                        used_cnt_next = used_cnt_reg + CNT_W'(1);
                    end
                    if (flags.lamp) begin
                        lamp_cnt_next = lamp_cnt_reg + CNT_W'(1);
                    end
                end else begin
                    m_status_next = lalf_pkg::ST_FULL;
                end
                m_valid_next = 1'b1;
                state_next   = OUT;
            end
            SRD: begin
                state_next = SCHK;
            end
            SCHK: begin
                if (flags.used) begin
                    m_status_next = lalf_pkg::ST_FRAME;
                    m_addr_next   = tbl_rd_data;
                    m_cmd_next    = cmd_reg;
                    m_seq_next    = seq_reg;
                    m_hue_next    = hue_reg;
                    m_sat_next    = sat_reg;
                    m_val_next    = val_reg;
                    m_last_next   = (seen_cnt_reg + CNT_W'(1) == used_cnt_reg);
                    seq_next      = seq_reg + 8'd1;
                    seen_cnt_next = seen_cnt_reg + CNT_W'(1);
                    m_valid_next  = 1'b1;
                    state_next    = OUT;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = SRD;
                end
            end
            OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = SRD;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase

        // count after this word's update, low 5 bits
        lamp_ext     = {{lalf_pkg::COUNT_W{1'b0}}, lamp_cnt_next};
        m_count_next = (m_valid_next && !m_valid_reg) ? lamp_ext[lalf_pkg::COUNT_W-1:0]
                                                      : m_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            efound_reg   <= 1'b0;
            used_cnt_reg <= '0;
            lamp_cnt_reg <= '0;
            seen_cnt_reg <= '0;
            seq_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            efound_reg   <= efound_next;
            used_cnt_reg <= used_cnt_next;
            lamp_cnt_reg <= lamp_cnt_next;
            seen_cnt_reg <= seen_cnt_next;
            seq_reg      <= seq_next;
            m_valid_reg  <= m_valid_next;
            m_last_reg   <= m_last_next;
        end
        idx_reg      <= idx_next;
        chk_idx_reg  <= chk_idx_next;
        eidx_reg     <= eidx_next;
        addr_reg     <= addr_next;
        cmd_reg      <= cmd_next;
        hue_reg      <= hue_next;
        sat_reg      <= sat_next;
        val_reg      <= val_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_addr_reg   <= m_addr_next;
        m_cmd_reg    <= m_cmd_next;
        m_seq_reg    <= m_seq_next;
        m_hue_reg    <= m_hue_next;
        m_sat_reg    <= m_sat_next;
        m_val_reg    <= m_val_next;
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_val_reg, m_sat_reg, m_hue_reg, m_seq_reg, m_cmd_reg,
                       m_addr_reg, m_count_reg};

    // a result word only waits in OUT, and input is closed meanwhile
    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!s_tready && state_reg == OUT))
        else $error("result word pending outside OUT");

    // visible lamps are a subset of used entries
    a_lamp_le_used: assert property (@(posedge aclk) disable iff (!aresetn)
        lamp_cnt_reg <= used_cnt_reg)
        else $error("lamp count above used count");

    // a table write always produces an ADDED result next cycle
    a_write_added: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (m_tvalid && m_tuser == lalf_pkg::ST_ADDED && m_tlast))
        else $error("table write without ADDED result");

    // sending never runs past the number of used entries
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SRD || state_reg == SCHK) |-> (seen_cnt_reg < used_cnt_reg))
        else $error("send scan past last used entry");

endmodule

@@ rtl/lalf_table.sv @@
module lalf_table #(
    parameter int TABLE_ENTRIES = lalf_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [lalf_pkg::ADDR_W-1:0] wr_data,
    input  logic [IDX_W-1:0]            rd_idx,
    output logic [lalf_pkg::ADDR_W-1:0] rd_data
);

    logic [lalf_pkg::ADDR_W-1:0] mem [TABLE_ENTRIES];
    logic [lalf_pkg::ADDR_W-1:0] rd_q_reg;
    logic [TABLE_ENTRIES-1:0]    valid_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_q_reg <= mem[rd_idx];
    end

    // never-written entries read as zero (empty)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

@@ rtl/lalf_match.sv @@
module lalf_match (
    input  logic [lalf_pkg::ADDR_W-1:0] entry,
    input  logic [lalf_pkg::ADDR_W-1:0] key,
    output lalf_pkg::match_t            flags
);

    always_comb begin
        flags.used = (entry[63:56] != '0);
        flags.lamp = (entry[63:56] != '0) && (entry[55:48] != '0) &&
                     (entry[47:40] != '0) && (entry[39:32] != '0);
        flags.hit  = (entry == key);
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS       = lalf_pkg::TABLE_ENTRIES_DEF;
    localparam int RAND_REQS   = 91;
    localparam int QUIET_MAX   = 2000;  // cycles with no word moving on either side
    localparam int TAIL_CYCLES = 64;    // > one full-table send scan
    localparam int PRINT_MAX   = 40;    // cap on mismatch lines

    // One request word toward the core. drain marks a hold-off point in the
    // request queue, not a word on the bus.
    typedef struct {
        bit          drain;
        logic        cmd;
        logic [7:0]  len;
        logic [63:0] addr;
        logic [7:0]  kind;
        logic [7:0]  lcmd;
        logic [7:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  val;
    } lamp_req_t;

    typedef struct {
        lalf_pkg::status_t status;
        logic [4:0]  count;
        logic [63:0] addr;
        logic [7:0]  cmd;
        logic [7:0]  seq;
        logic [7:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        logic        last;
    } lamp_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lalf_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lalf_pkg::M_TDATA_W-1:0] m_tdata;
    logic [lalf_pkg::M_TUSER_W-1:0] m_tuser;
    logic                           m_tlast;

    lamp_address_learning_and_framing_core #(
        .TABLE_ENTRIES(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the core state
    logic [63:0]  lamp_table [SLOTS];
    logic [7:0]   seq_ctr;

    lamp_req_t    req_q [$];        // requests still to drive
    lamp_result_t due_results [$];  // expected result words, oldest first
    lamp_req_t    cur_req;          // word currently on s_tdata

    int errors      = 0;
    int words_sent  = 0;
    int words_taken = 0;
    int n_learn     = 0;
    int n_send      = 0;
    int n_results   = 0;
    int status_hits [6];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Entries whose bytes 0..3 are all nonzero
    function automatic logic [4:0] visible_lamps();
        int n = 0;
        foreach (lamp_table[k])
            if (lamp_table[k][63:56] != 0 && lamp_table[k][55:48] != 0 &&
                lamp_table[k][47:40] != 0 && lamp_table[k][39:32] != 0)
                n++;
        return n[4:0];
    endfunction

    // Packet check, duplicate search over used entries, then lowest empty slot.
    // An address with byte 0 zero never matches and lands in an empty slot,
    // which stays empty.
    function automatic lalf_pkg::status_t learn_address(lamp_req_t r);
        if (r.len != lalf_pkg::LEN_VALID || r.kind != lalf_pkg::KIND_VALID ||
            !(r.lcmd == lalf_pkg::LCMD_A || r.lcmd == lalf_pkg::LCMD_B ||
              r.lcmd == lalf_pkg::LCMD_C))
            return lalf_pkg::ST_REJECT;
        foreach (lamp_table[k])
            if (lamp_table[k][63:56] != 0 && lamp_table[k] == r.addr)
                return lalf_pkg::ST_KNOWN;
        foreach (lamp_table[k])
            if (lamp_table[k][63:56] == 0) begin
                lamp_table[k] = r.addr;
                return lalf_pkg::ST_ADDED;
            end
        return lalf_pkg::ST_FULL;
    endfunction

    function automatic void expect_result(lalf_pkg::status_t st, logic [4:0] cnt,
                                          logic [63:0] a, logic [7:0] c, logic [7:0] sq,
                                          logic [7:0] h, logic [7:0] sa, logic [7:0] v,
                                          logic lst);
        lamp_result_t w;
        w.status = st;
        w.count  = cnt;
        w.addr   = a;
        w.cmd    = c;
        w.seq    = sq;
        w.hue    = h;
        w.sat    = sa;
        w.val    = v;
        w.last   = lst;
        due_results.push_back(w);
        status_hits[int'(st)]++;
    endfunction

    function automatic void apply_request(lamp_req_t r);
        int                used = 0;
        int                seen = 0;
        logic [4:0]        lamps;
        lalf_pkg::status_t st;
        if (r.cmd == lalf_pkg::CMD_LEARN) begin
            st = learn_address(r);
            // count is taken after the table update
            expect_result(st, visible_lamps(), '0, '0, '0, '0, '0, '0, 1'b1);
            return;
        end
        lamps = visible_lamps();
        foreach (lamp_table[k])
            if (lamp_table[k][63:56] != 0)
                used++;
        if (used == 0) begin
            // empty table: single word, counter untouched
            expect_result(lalf_pkg::ST_NOLAMP, lamps, '0, '0, '0, '0, '0, '0, 1'b1);
            return;
        end
        foreach (lamp_table[k])
            if (lamp_table[k][63:56] != 0) begin
                seen++;
                expect_result(lalf_pkg::ST_FRAME, lamps, lamp_table[k], r.lcmd, seq_ctr,
                              r.hue, r.sat, r.val, seen == used);
                seq_ctr++;  // wraps at 256
            end
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    function automatic lamp_req_t learn_req(logic [63:0] a, logic [7:0] c);
        lamp_req_t r;
        r = '{drain: 1'b0, cmd: lalf_pkg::CMD_LEARN, len: lalf_pkg::LEN_VALID, addr: a,
              kind: lalf_pkg::KIND_VALID, lcmd: c, hue: 8'($urandom), sat: 8'($urandom),
              val: 8'($urandom)};
        return r;
    endfunction

    // Packet fields of a send word are don't-care; fill them with noise.
    function automatic lamp_req_t send_req(logic [7:0] c, logic [7:0] h, logic [7:0] sa,
                                           logic [7:0] v);
        lamp_req_t r;
        r = '{drain: 1'b0, cmd: lalf_pkg::CMD_SEND, len: 8'($urandom),
              addr: {$urandom, $urandom}, kind: 8'($urandom), lcmd: c, hue: h, sat: sa,
              val: v};
        return r;
    endfunction

    function automatic lamp_req_t pause_req();
        lamp_req_t r;
        r = '{drain: 1'b1, cmd: lalf_pkg::CMD_LEARN, default: '0};
        return r;
    endfunction

    function automatic logic [7:0] valid_lcmd();
        case ($urandom_range(0, 2))
            0: return lalf_pkg::LCMD_A;
            1: return lalf_pkg::LCMD_B;
            default: return lalf_pkg::LCMD_C;
        endcase
    endfunction

    // Random address, sometimes with byte 0 (empty marker) or a lamp byte zeroed
    function automatic logic [63:0] pick_address();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: a[63:56] = 8'h00;
            1: a[55:48] = 8'h00;
            2: a[39:32] = 8'h00;
            default: ;
        endcase
        return a;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= PRINT_MAX)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps; a drain marker holds the
    // next word back until every expected result has come out.
    // ------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 0;

    always @(negedge aclk) begin : drive_requests
        logic      nxt_valid;
        lamp_req_t r;
        if (aresetn) begin
            nxt_valid = s_tvalid;
            if (s_tvalid && words_taken == words_sent)
                nxt_valid = 1'b0;  // taken at the last rising edge
            if (!nxt_valid) begin
                if (req_q.size() != 0 && req_q[0].drain) begin
                    if (due_results.size() == 0)
                        void'(req_q.pop_front());
                end else if (gap_left != 0) begin
                    gap_left--;
                end else if (req_q.size() != 0) begin
                    r       = req_q.pop_front();
                    cur_req = r;
                    s_tdata <= {r.val, r.sat, r.hue, r.lcmd, r.kind, r.addr, r.len};
                    s_tuser <= r.cmd;
                    nxt_valid = 1'b1;
                    words_sent++;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Receiver backpressure: switches among always ready, coin flip,
    // one-in-five and mostly stalled.
    // ------------------------------------------------------------------
    int ready_mode = 0;
    int mode_left  = 0;
    int phase      = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom);
                2: m_tready <= (phase % 5 == 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each result word.
    // m_tdata low bit up: count[4:0], addr[68:5], cmd[76:69], seq[84:77],
    // hue[92:85], sat[100:93], val[108:101]
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_ports
        lamp_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                words_taken++;
                apply_request(cur_req);
                if (cur_req.cmd == lalf_pkg::CMD_LEARN)
                    n_learn++;
                else
                    n_send++;
            end
            if (m_tvalid && m_tready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= PRINT_MAX)
                        $display("%0t: unexpected result word, expected none, got status %0d data %h",
                                 $time, m_tuser, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 64'(want.status), 64'(m_tuser));
                    check_field("lamp_count", 64'(want.count), 64'(m_tdata[4:0]));
                    check_field("frame_address", want.addr, m_tdata[68:5]);
                    check_field("frame_cmd", 64'(want.cmd), 64'(m_tdata[76:69]));
                    check_field("frame_seq", 64'(want.seq), 64'(m_tdata[84:77]));
                    check_field("frame_hue", 64'(want.hue), 64'(m_tdata[92:85]));
                    check_field("frame_sat", 64'(want.sat), 64'(m_tdata[100:93]));
                    check_field("frame_val", 64'(want.val), 64'(m_tdata[108:101]));
                    check_field("last", 64'(want.last), 64'(m_tlast));
                end
            end
        end
    end

    // Watchdog on a stuck core
    int quiet = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_MAX) begin
                    $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                             $time, quiet, due_results.size());
                    $display("FAIL lamp_address_learning_and_framing_core");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          roll;
        logic [63:0] a;
        lamp_req_t   r;
        logic [63:0] seen_addrs [$];

        foreach (lamp_table[k])
            lamp_table[k] = '0;
        seq_ctr = '0;

        // Directed: empty-table send, each rejection cause at its extremes,
        // duplicates, zero byte 0 entries, non-lamp entries, frame fields
        req_q.push_back(send_req(8'h00, 8'h00, 8'h00, 8'h00));
        r = learn_req('1, lalf_pkg::LCMD_A); r.len  = 8'h00;   req_q.push_back(r);
        r = learn_req('1, lalf_pkg::LCMD_B); r.len  = 8'hFF;   req_q.push_back(r);
        r = learn_req('1, lalf_pkg::LCMD_C); r.kind = 8'h00;   req_q.push_back(r);
        r = learn_req('1, lalf_pkg::LCMD_A); r.kind = 8'hFF;   req_q.push_back(r);
        req_q.push_back(learn_req('1, 8'h00));
        req_q.push_back(learn_req('1, 8'h04));
        req_q.push_back(learn_req('1, 8'hFF));
        req_q.push_back(learn_req('1, lalf_pkg::LCMD_A));                      // added, lamp
        req_q.push_back(learn_req('1, lalf_pkg::LCMD_B));                      // known
        req_q.push_back(learn_req(64'h00FF_FFFF_FFFF_FFFF, lalf_pkg::LCMD_C)); // stays empty
        req_q.push_back(send_req(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        req_q.push_back(learn_req('0, lalf_pkg::LCMD_A));                  // reuses empty slot
        req_q.push_back(learn_req(64'h0100_0000_0000_0001, lalf_pkg::LCMD_B)); // used, not a lamp
        req_q.push_back(learn_req(64'h0101_0101_0000_0000, lalf_pkg::LCMD_C)); // lamp
        req_q.push_back(learn_req(64'h0100_0000_0000_0001, lalf_pkg::LCMD_A)); // known
        req_q.push_back(learn_req('0, lalf_pkg::LCMD_B));
        req_q.push_back(pause_req());
        req_q.push_back(send_req(8'h00, 8'h00, 8'h00, 8'h00));
        req_q.push_back(send_req(8'hA5, 8'h5A, 8'hC3, 8'h3C));
        seen_addrs.push_back('1);
        seen_addrs.push_back(64'h0101_0101_0000_0000);

        // Random: mostly well-formed learns that fill the table and then hit
        // the full case, duplicates, broken packets, noise and sends.
        for (int i = 0; i < RAND_REQS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                a = pick_address();
                seen_addrs.push_back(a);
                r = learn_req(a, valid_lcmd());
            end else if (roll < 60) begin
                r = learn_req(seen_addrs[$urandom_range(0, seen_addrs.size() - 1)],
                              valid_lcmd());
            end else if (roll < 70) begin
                r = learn_req(pick_address(), valid_lcmd());
                case ($urandom_range(0, 2))
                    0: do r.len = 8'($urandom); while (r.len == lalf_pkg::LEN_VALID);
                    1: do r.kind = 8'($urandom); while (r.kind == lalf_pkg::KIND_VALID);
                    default:
                        do r.lcmd = 8'($urandom);
                        while (r.lcmd == lalf_pkg::LCMD_A || r.lcmd == lalf_pkg::LCMD_B ||
                               r.lcmd == lalf_pkg::LCMD_C);
                endcase
            end else if (roll < 75) begin
                r = send_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                r.cmd = 1'($urandom);
            end else begin
                r = send_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            req_q.push_back(r);
            if (i % 37 == 36)
                req_q.push_back(pause_req());
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        // catch stray words after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run: %0d learn and %0d send requests, %0d result words, seq counter at %0d",
                 n_learn, n_send, n_results, seq_ctr);
        $display("statuses: added %0d known %0d full %0d rejected %0d frame %0d no-lamps %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (errors == 0) begin
            $display("PASS lamp_address_learning_and_framing_core");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL lamp_address_learning_and_framing_core");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lalf_pkg.sv
rtl/lalf_table.sv
rtl/lalf_match.sv
rtl/lamp_address_learning_and_framing_core.sv
tb/tb.sv
